// ===== design/pdu_pkg.sv =====
// Shared types, character constants and decode functions for the percent decoder.
// Used by pdu_ctrl, pdu_datapath and percent_decode_utf8; no dependencies.
package pdu_pkg;

    // Hold queue: up to 11 held characters plus the incoming one
    localparam int QDEPTH = 12;

    localparam logic [7:0] CH_PCT   = 8'h25;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_SPACE = 8'h20;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_of_input;
    } pdu_in_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       run_last;
        logic       message_last;
        logic       truncated;
    } pdu_out_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_CHUNK,
        ST_FLUSH
    } pdu_state_t;

    // One result-producing step of the scan
    typedef enum logic [2:0] {
        ACT_NONE,
        ACT_CHAR,   // plain character, '+' mapped to space
        ACT_LIT,    // literal '%' for an invalid lead
        ACT_PAIR,   // hex pair of an escape chunk
        ACT_RAW     // cut-off chunk byte, flagged truncated
    } pdu_act_t;

    typedef struct packed {
        logic     load;        // append incoming char to the hold queue
        logic     direct;      // plain char bypasses the queue to the output
        pdu_act_t act;
        logic     pairs_load;  // first pair of a chunk: load pair counter
        logic     finish;      // end of transaction's scan: release staged result
    } pdu_cmd_t;

    typedef struct packed {
        logic [3:0] cnt;
        logic       head_pct;
        logic [2:0] lead_pairs;
        logic       enough;
        logic       last;
        logic       out_free;
        logic [2:0] pairs_left;
        logic       in_pct;
    } pdu_status_t;

    // {valid, value} of a hex digit
    function automatic logic [4:0] hex_digit(input logic [7:0] c);
        logic [4:0] r;
        r = 5'b0;
        if (c >= 8'h30 && c <= 8'h39)
            r = {1'b1, c[3:0]};
        else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46))
            r = {1'b1, 4'(c[3:0] + 4'd9)};
        return r;
    endfunction

    function automatic logic [7:0] to_lower(input logic [7:0] c);
        logic [7:0] r;
        r = c;
        if (c >= 8'h41 && c <= 8'h5A)
            r = c | 8'h20;
        return r;
    endfunction

    // Number of hex pairs in the chunk picked by the lead; 0 for no valid lead
    function automatic logic [2:0] lead_pairs(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] la;
        logic [7:0] lb;
        logic [4:0] hb;
        logic       bhex;
        logic [2:0] r;
        la   = to_lower(a);
        lb   = to_lower(b);
        hb   = hex_digit(b);
        bhex = hb[4];
        r    = 3'd0;
        if (a >= 8'h30 && a <= 8'h37 && bhex)
            r = 3'd1;
        else if (la == 8'h63 && ((b >= 8'h32 && b <= 8'h39) || (lb >= 8'h61 && lb <= 8'h66)))
            r = 3'd2;
        else if (la == 8'h64 && bhex)
            r = 3'd2;
        else if (la == 8'h65 && bhex)
            r = 3'd3;
        else if (la == 8'h66 && b >= 8'h30 && b <= 8'h34)
            r = 3'd4;
        return r;
    endfunction

    // Byte from the leading hex digits of a pair
    function automatic logic [7:0] pair_value(input logic [7:0] a, input logic [7:0] b);
        logic [4:0] ha;
        logic [4:0] hb;
        logic [7:0] r;
        ha = hex_digit(a);
        hb = hex_digit(b);
        if (!ha[4])
            r = 8'h00;
        else if (!hb[4])
            r = {4'h0, ha[3:0]};
        else
            r = {ha[3:0], hb[3:0]};
        return r;
    endfunction

    function automatic logic [7:0] map_plain(input logic [7:0] c);
        return (c == CH_PLUS) ? CH_SPACE : c;
    endfunction

endpackage

// ===== design/pdu_datapath.sv =====
// Datapath of the percent decoder: hold queue, pair counter, staging and output registers.
// Driven by pdu_ctrl through pdu_pkg::pdu_cmd_t; depends on pdu_pkg.
module pdu_datapath (
    input  logic                  clk,
    input  logic                  rst_n,
    input  pdu_pkg::pdu_cmd_t     cmd,
    output pdu_pkg::pdu_status_t  status,
    input  pdu_pkg::pdu_in_t      enc_data,
    output logic                  dec_valid,
    input  logic                  dec_stall,
    output pdu_pkg::pdu_out_t     dec_data
);

    logic [pdu_pkg::QDEPTH-1:0][7:0] q_reg, q_next;
    logic [3:0]                      cnt_reg, cnt_next;
    logic                            last_reg, last_next;
    logic [2:0]                      pairs_reg, pairs_next;
    logic                            stg_valid_reg, stg_valid_next;
    logic [7:0]                      stg_byte_reg, stg_byte_next;
    logic                            stg_trunc_reg, stg_trunc_next;
    logic                            out_valid_reg, out_valid_next;
    pdu_pkg::pdu_out_t               out_data_reg, out_data_next;

    logic       out_free;
    logic [2:0] lp;
    logic [3:0] need;
    logic [7:0] new_byte;
    logic       new_trunc;

    // Status toward the controller
    assign out_free = !out_valid_reg || !dec_stall;
    assign lp       = pdu_pkg::lead_pairs(q_reg[1], q_reg[2]);
    assign need     = {1'b0, lp} + {lp, 1'b0};

    always_comb
    begin
        status.cnt        = cnt_reg;
        status.head_pct   = (q_reg[0] == pdu_pkg::CH_PCT);
        status.lead_pairs = lp;
        status.enough     = (cnt_reg >= need);
        status.last       = last_reg;
        status.out_free   = out_free;
        status.pairs_left = pairs_reg;
        status.in_pct     = (enc_data.in_byte == pdu_pkg::CH_PCT);
    end

    // Next-value logic
    always_comb
    begin
        q_next         = q_reg;
        cnt_next       = cnt_reg;
        last_next      = last_reg;
        pairs_next     = pairs_reg;
        stg_valid_next = stg_valid_reg;
        stg_byte_next  = stg_byte_reg;
        stg_trunc_next = stg_trunc_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        new_byte       = q_reg[0];
        new_trunc      = 1'b0;

        if (out_valid_reg && !dec_stall)
            out_valid_next = 1'b0;

        // append incoming character
        if (cmd.load)
        begin
            for (int i = 0; i < pdu_pkg::QDEPTH; i++)
            begin
                if (cnt_reg == 4'(i))
                    q_next[i] = enc_data.in_byte;
            end
            cnt_next  = cnt_reg + 4'd1;
            last_next = enc_data.end_of_input;
        end

        // result byte and queue consumption per action
        case (cmd.act)
            pdu_pkg::ACT_CHAR:
            begin
                new_byte = pdu_pkg::map_plain(q_reg[0]);
                q_next   = {8'h00, q_reg[pdu_pkg::QDEPTH-1:1]};
                cnt_next = cnt_reg - 4'd1;
            end
            pdu_pkg::ACT_LIT:
            begin
                new_byte = pdu_pkg::CH_PCT;
                q_next   = {8'h00, q_reg[pdu_pkg::QDEPTH-1:1]};
                cnt_next = cnt_reg - 4'd1;
            end
            pdu_pkg::ACT_RAW:
            begin
                new_byte  = q_reg[0];
                new_trunc = 1'b1;
                q_next    = {8'h00, q_reg[pdu_pkg::QDEPTH-1:1]};
                cnt_next  = cnt_reg - 4'd1;
            end
            pdu_pkg::ACT_PAIR:
            begin
                new_byte   = pdu_pkg::pair_value(q_reg[1], q_reg[2]);
                q_next     = {24'h000000, q_reg[pdu_pkg::QDEPTH-1:3]};
                cnt_next   = cnt_reg - 4'd3;
                pairs_next = cmd.pairs_load ? (lp - 3'd1) : (pairs_reg - 3'd1);
            end
            default:
            begin
                new_byte  = q_reg[0];
                new_trunc = 1'b0;
            end
        endcase

        // new result: previous staged one moves out as a non-final result
        if (cmd.act != pdu_pkg::ACT_NONE)
        begin
            if (stg_valid_reg)
            begin
                out_data_next.out_byte     = stg_byte_reg;
                out_data_next.run_last     = 1'b0;
                out_data_next.message_last = 1'b0;
                out_data_next.truncated    = stg_trunc_reg;
                out_valid_next             = 1'b1;
            end
            stg_valid_next = 1'b1;
            stg_byte_next  = new_byte;
            stg_trunc_next = new_trunc;
        end

        // end of scan: staged result is the transaction's last
        if (cmd.finish && stg_valid_reg)
        begin
            out_data_next.out_byte     = stg_byte_reg;
            out_data_next.run_last     = 1'b1;
            out_data_next.message_last = last_reg;
            out_data_next.truncated    = stg_trunc_reg;
            out_valid_next             = 1'b1;
            stg_valid_next             = 1'b0;
        end

        // plain character with nothing held goes straight out
        if (cmd.direct)
        begin
            out_data_next.out_byte     = pdu_pkg::map_plain(enc_data.in_byte);
            out_data_next.run_last     = 1'b1;
            out_data_next.message_last = enc_data.end_of_input;
            out_data_next.truncated    = 1'b0;
            out_valid_next             = 1'b1;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= 4'd0;
            last_reg      <= 1'b0;
            pairs_reg     <= 3'd0;
            stg_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cnt_reg       <= cnt_next;
            last_reg      <= last_next;
            pairs_reg     <= pairs_next;
            stg_valid_reg <= stg_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        q_reg         <= q_next;
        stg_byte_reg  <= stg_byte_next;
        stg_trunc_reg <= stg_trunc_next;
        out_data_reg  <= out_data_next;
    end

    assign dec_valid = out_valid_reg;
    assign dec_data  = out_data_reg;

endmodule

// ===== design/pdu_ctrl.sv =====
// Controller of the percent decoder: scan sequencer over the hold queue.
// Issues pdu_pkg::pdu_cmd_t to pdu_datapath; depends on pdu_pkg.
module pdu_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 enc_valid,
    output logic                 enc_stall,
    input  pdu_pkg::pdu_status_t status,
    output pdu_pkg::pdu_cmd_t    cmd
);

    pdu_pkg::pdu_state_t state_reg, state_next;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            pdu_pkg::ST_IDLE:
            begin
                if (enc_valid && status.out_free &&
                    !(status.cnt == 4'd0 && !status.in_pct))
                    state_next = pdu_pkg::ST_SCAN;
            end
            pdu_pkg::ST_SCAN:
            begin
                if (status.out_free)
                begin
                    if (status.cnt == 4'd0)
                        state_next = pdu_pkg::ST_IDLE;
                    else if (!status.head_pct)
                        state_next = pdu_pkg::ST_SCAN;
                    else if (status.cnt < 4'd3)
                        state_next = status.last ? pdu_pkg::ST_FLUSH : pdu_pkg::ST_IDLE;
                    else if (status.lead_pairs == 3'd0)
                        state_next = pdu_pkg::ST_SCAN;
                    else if (!status.enough)
                        state_next = status.last ? pdu_pkg::ST_FLUSH : pdu_pkg::ST_IDLE;
                    else if (status.lead_pairs != 3'd1)
                        state_next = pdu_pkg::ST_CHUNK;
                end
            end
            pdu_pkg::ST_CHUNK:
            begin
                if (status.out_free && status.pairs_left == 3'd1)
                    state_next = pdu_pkg::ST_SCAN;
            end
            pdu_pkg::ST_FLUSH:
            begin
                if (status.out_free && status.cnt == 4'd0)
                    state_next = pdu_pkg::ST_IDLE;
            end
            default:
                state_next = pdu_pkg::ST_IDLE;
        endcase
    end

    // Commands
    always_comb
    begin
        cmd.load       = 1'b0;
        cmd.direct     = 1'b0;
        cmd.act        = pdu_pkg::ACT_NONE;
        cmd.pairs_load = 1'b0;
        cmd.finish     = 1'b0;
        enc_stall      = 1'b1;
        case (state_reg)
            pdu_pkg::ST_IDLE:
            begin
                enc_stall = !status.out_free;
                if (enc_valid && status.out_free)
                begin
                    if (status.cnt == 4'd0 && !status.in_pct)
                        cmd.direct = 1'b1;
                    else
                        cmd.load = 1'b1;
                end
            end
            pdu_pkg::ST_SCAN:
            begin
                if (status.out_free)
                begin
                    if (status.cnt == 4'd0)
                        cmd.finish = 1'b1;
                    else if (!status.head_pct)
                        cmd.act = pdu_pkg::ACT_CHAR;
                    else if (status.cnt < 4'd3)
                    begin
                        if (status.last)
                            cmd.act = pdu_pkg::ACT_RAW;
                        else
                            cmd.finish = 1'b1;
                    end
                    else if (status.lead_pairs == 3'd0)
                        cmd.act = pdu_pkg::ACT_LIT;
                    else if (!status.enough)
                    begin
                        if (status.last)
                            cmd.act = pdu_pkg::ACT_RAW;
                        else
                            cmd.finish = 1'b1;
                    end
                    else
                    begin
                        cmd.act        = pdu_pkg::ACT_PAIR;
                        cmd.pairs_load = 1'b1;
                    end
                end
            end
            pdu_pkg::ST_CHUNK:
            begin
                if (status.out_free)
                    cmd.act = pdu_pkg::ACT_PAIR;
            end
            pdu_pkg::ST_FLUSH:
            begin
                if (status.out_free)
                begin
                    if (status.cnt == 4'd0)
                        cmd.finish = 1'b1;
                    else
                        cmd.act = pdu_pkg::ACT_RAW;
                end
            end
            default:
            begin
                enc_stall = 1'b1;
            end
        endcase
    end

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= pdu_pkg::ST_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

// ===== design/percent_decode_utf8.sv =====
// A plain character with no escape held is taken directly and its byte appears on
// dec_data the next cycle, one transaction per cycle sustained while the output is not stalled.
// Any other character is first loaded into the hold queue and then scanned: one scan step
// per result byte, one wrap-up step, all through the single scan sequencer on the queue.
// Reset (async, rst_n low) returns to idle with an empty hold queue and no output pending;
// the queue's byte storage itself is not cleared.
module percent_decode_utf8 (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              enc_valid,
    output logic              enc_stall,
    input  pdu_pkg::pdu_in_t  enc_data,
    output logic              dec_valid,
    input  logic              dec_stall,
    output pdu_pkg::pdu_out_t dec_data
);

    pdu_pkg::pdu_cmd_t    cmd;
    pdu_pkg::pdu_status_t status;

    // Scan sequencer
    pdu_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .enc_valid (enc_valid),
        .enc_stall (enc_stall),
        .status    (status),
        .cmd       (cmd)
    );

    // Hold queue and output path
    pdu_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .enc_data  (enc_data),
        .dec_valid (dec_valid),
        .dec_stall (dec_stall),
        .dec_data  (dec_data)
    );

endmodule
